>>> sv/brb_pkg.sv
package brb_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 2;
  localparam int DATA_W   = 8;
  localparam int AMOUNT_W = 13;
  localparam int OFFSET_W = 12;
  localparam int STATUS_W = 2;
  localparam int STORED_W = 13;

  // common width for comparing counts, lengths and offsets
  localparam int WIDE_W = ((AMOUNT_W > CNT_W) ? AMOUNT_W : CNT_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_PEEK    = 2'd1,
    MODE_CONSUME = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } brb_cmd_t;

endpackage

>>> sv/brb_ctrl.sv
module brb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output brb_pkg::brb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    cmd_o.load    = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/brb_datapath.sv
module brb_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brb_pkg::brb_cmd_t             cmd_i,
  input  logic [brb_pkg::MODE_W-1:0]    mode_i,
  input  logic [brb_pkg::DATA_W-1:0]    data_in_i,
  input  logic                          span_start_i,
  input  logic [brb_pkg::AMOUNT_W-1:0]  amount_i,
  input  logic [brb_pkg::OFFSET_W-1:0]  offset_i,
  output logic [brb_pkg::DATA_W-1:0]    data_out_o,
  output logic [brb_pkg::STATUS_W-1:0]  status_o,
  output logic [brb_pkg::STORED_W-1:0]  stored_o,
  output logic [brb_pkg::STORED_W-1:0]  free_bytes_o
);

  localparam int AW = brb_pkg::ADDR_W;
  localparam int CW = brb_pkg::CNT_W;
  localparam int WW = brb_pkg::WIDE_W;
  localparam int LW = brb_pkg::AMOUNT_W;

  // ring pointer advance, step never above the capacity
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW:0] step);
    logic [AW:0] s;
    s = {1'b0, base} + step;
    if (s >= (AW+1)'(brb_pkg::CAPACITY)) begin
      s = s - (AW+1)'(brb_pkg::CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  logic [brb_pkg::DATA_W-1:0] mem [brb_pkg::CAPACITY];

  // latched item
  brb_pkg::mode_e               mode_q;
  logic [brb_pkg::DATA_W-1:0]   data_q;
  logic                         span_start_q;
  logic [LW-1:0]                amount_q;
  logic [brb_pkg::OFFSET_W-1:0] offset_q;

  // ring state
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [LW-1:0] span_rem_q, span_rem_d;
  logic          span_rej_q, span_rej_d;

  // result staging
  brb_pkg::status_e           res_status_q, res_status_d;
  logic                       peek_ok_q, peek_ok_d;
  logic [brb_pkg::DATA_W-1:0] rd_data_q;

  // output register
  logic [brb_pkg::DATA_W-1:0]   data_out_q;
  logic [brb_pkg::STATUS_W-1:0] status_q;
  logic [brb_pkg::STORED_W-1:0] stored_q;
  logic [brb_pkg::STORED_W-1:0] free_q;

  logic [WW-1:0] fill_w, free_w, amount_w, offset_w;
  logic [AW-1:0] peek_addr;
  logic          wr_en;
  logic          try_push;

  assign fill_w    = WW'(fill_q);
  assign free_w    = WW'(brb_pkg::CAPACITY) - fill_w;
  assign amount_w  = WW'(amount_q);
  assign offset_w  = WW'(offset_q);
  assign peek_addr = wrap_add(tail_q, (AW+1)'(offset_q));

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    span_rem_d   = span_rem_q;
    span_rej_d   = span_rej_q;
    res_status_d = brb_pkg::ST_OK;
    peek_ok_d    = 1'b0;
    wr_en        = 1'b0;
    try_push     = 1'b0;
    case (mode_q)
      brb_pkg::MODE_PUSH: begin
        if (!span_start_q && (span_rem_q == '0)) begin
          // stray byte is a one-byte span
          span_rej_d = 1'b0;
          try_push   = 1'b1;
        end else if (span_start_q) begin
          if (amount_q == '0) begin
            span_rem_d = '0;
            span_rej_d = 1'b0;
          end else begin
            span_rem_d = amount_q - LW'(1);
            if (amount_w > free_w) begin
              span_rej_d   = 1'b1;
              res_status_d = brb_pkg::ST_OVERFLOW;
            end else begin
              span_rej_d = 1'b0;
              try_push   = 1'b1;
            end
          end
        end else begin
          span_rem_d = span_rem_q - LW'(1);
          if (span_rej_q) begin
            res_status_d = brb_pkg::ST_OVERFLOW;
          end else begin
            try_push = 1'b1;
          end
        end
        if (try_push) begin
          if (fill_w >= WW'(brb_pkg::CAPACITY)) begin
            res_status_d = brb_pkg::ST_OVERFLOW;
          end else begin
            wr_en  = 1'b1;
            head_d = wrap_add(head_q, (AW+1)'(1));
            fill_d = fill_q + CW'(1);
          end
        end
      end
      brb_pkg::MODE_PEEK: begin
        if (offset_w >= fill_w) begin
          res_status_d = brb_pkg::ST_RANGE;
        end else begin
          peek_ok_d = 1'b1;
        end
      end
      brb_pkg::MODE_CONSUME: begin
        if (amount_w > fill_w) begin
          res_status_d = brb_pkg::ST_RANGE;
        end else begin
          tail_d = wrap_add(tail_q, (AW+1)'(amount_q));
          fill_d = fill_q - CW'(amount_q);
        end
      end
      brb_pkg::MODE_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        fill_d = '0;
      end
      default: begin
        res_status_d = brb_pkg::ST_OK;
      end
    endcase
  end

  // byte store, at most one write and one registered read per cycle, on execute only
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (wr_en) begin
        mem[head_q] <= data_q;
      end
      rd_data_q <= mem[peek_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q       <= brb_pkg::mode_e'(mode_i);
      data_q       <= data_in_i;
      span_start_q <= span_start_i;
      amount_q     <= amount_i;
      offset_q     <= offset_i;
    end
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      peek_ok_q    <= peek_ok_d;
    end
    if (cmd_i.load) begin
      data_out_q <= peek_ok_q ? rd_data_q : '0;
      status_q   <= res_status_q;
      stored_q   <= brb_pkg::STORED_W'(fill_q);
      free_q     <= brb_pkg::STORED_W'(WW'(brb_pkg::CAPACITY) - fill_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      span_rem_q <= '0;
      span_rej_q <= 1'b0;
    end else if (cmd_i.execute) begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      span_rem_q <= span_rem_d;
      span_rej_q <= span_rej_d;
    end
  end

  assign data_out_o   = data_out_q;
  assign status_o     = status_q;
  assign stored_o     = stored_q;
  assign free_bytes_o = free_q;

endmodule

>>> sv/byte_ring_buffer_peek_consume_core.sv
// channel  handshake             fields
// in       in_valid_i/in_stall_o mode_i data_in_i span_start_i amount_i offset_i
// out      out_valid_o/out_stall_i data_out_o status_o stored_o free_bytes_o
//
// each item passes three steps: capture, execute (byte store: a push write
// and a registered read for peek), result load into the output register
// the next item is taken while a finished result waits on a stalled output
// reset clears pointers, fill count and span state; the byte store is not cleared
// a stalled output holds the controller in its result step until the register frees
module byte_ring_buffer_peek_consume_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [brb_pkg::MODE_W-1:0]    mode_i,
  input  logic [brb_pkg::DATA_W-1:0]    data_in_i,
  input  logic                          span_start_i,
  input  logic [brb_pkg::AMOUNT_W-1:0]  amount_i,
  input  logic [brb_pkg::OFFSET_W-1:0]  offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [brb_pkg::DATA_W-1:0]    data_out_o,
  output logic [brb_pkg::STATUS_W-1:0]  status_o,
  output logic [brb_pkg::STORED_W-1:0]  stored_o,
  output logic [brb_pkg::STORED_W-1:0]  free_bytes_o
);

  brb_pkg::brb_cmd_t cmd;

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  brb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_i),
    .data_in_i    (data_in_i),
    .span_start_i (span_start_i),
    .amount_i     (amount_i),
    .offset_i     (offset_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .stored_o     (stored_o),
    .free_bytes_o (free_bytes_o)
  );

  // fill and free space always add up to the capacity
  a_fill_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((brb_pkg::STORED_W+1)'(stored_o) + (brb_pkg::STORED_W+1)'(free_bytes_o)
                     == (brb_pkg::STORED_W+1)'(brb_pkg::CAPACITY)))
    else $error("stored plus free differs from capacity");

  // one item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again while an item is in work");

  // a byte is only returned by a successful peek
  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != brb_pkg::ST_OK)) |-> (data_out_o == '0))
    else $error("nonzero data with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == brb_pkg::ST_OK) || (status_o == brb_pkg::ST_OVERFLOW)
                     || (status_o == brb_pkg::ST_RANGE)))
    else $error("undefined status code");

endmodule
